// ===== src/mou_pkg.sv =====
package mou_pkg;

   // field widths
   localparam int WHEEL_W = 16;
   localparam int HEAD_W  = 16;
   localparam int COEF_W  = 16;
   localparam int VEL_W   = 17;
   localparam int RATE_W  = 24;

   // rotation and divider chain
   localparam int ANGLE_STEPS = 16;                 // 8 .. 24
   localparam int QUOT_BITS   = 24;
   localparam int NUM_CELLS   = QUOT_BITS;
   localparam int CELL_IDX_W  = $clog2(NUM_CELLS);

   localparam int SUM_W  = 18;
   localparam int XY_W   = 32;
   localparam int Z_W    = 33;
   localparam int NUM_W  = 29;                      // 2 * |w| * 1024 + coef
   localparam int DEN_W  = COEF_W + 1;              // 2 * coef
   localparam int DSH_W  = DEN_W + QUOT_BITS;

   // gain correction 1/K in units of 2^-30
   localparam int KC_W = 31;
   localparam logic signed [KC_W-1:0] KC = 31'sd652032875;
   localparam int PROD_W      = XY_W + KC_W;
   localparam int ROUND_SHIFT = 44;
   localparam int VR_W        = PROD_W - ROUND_SHIFT;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [NUM_W-1:0]       rem;
      logic [QUOT_BITS-1:0]   quot;
      logic [DEN_W-1:0]       den;
      logic                   neg;
      logic                   kzero;
      logic                   ovf;
   } cell_data_type;

   // atan(2^-i) in 2^32-per-turn units
   function automatic logic signed [Z_W-1:0] atan_units(input logic [CELL_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = 33'sd536870912;
         5'd1:    val = 33'sd316933406;
         5'd2:    val = 33'sd167458907;
         5'd3:    val = 33'sd85004756;
         5'd4:    val = 33'sd42667331;
         5'd5:    val = 33'sd21354465;
         5'd6:    val = 33'sd10679838;
         5'd7:    val = 33'sd5340245;
         5'd8:    val = 33'sd2670163;
         5'd9:    val = 33'sd1335087;
         5'd10:   val = 33'sd667544;
         5'd11:   val = 33'sd333772;
         5'd12:   val = 33'sd166886;
         5'd13:   val = 33'sd83443;
         5'd14:   val = 33'sd41722;
         5'd15:   val = 33'sd20861;
         5'd16:   val = 33'sd10430;
         5'd17:   val = 33'sd5215;
         5'd18:   val = 33'sd2608;
         5'd19:   val = 33'sd1304;
         5'd20:   val = 33'sd652;
         5'd21:   val = 33'sd326;
         5'd22:   val = 33'sd163;
         5'd23:   val = 33'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== src/mou_req_if.sv =====
interface mou_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [mou_pkg::WHEEL_W-1:0] wheel_fl;
   logic signed [mou_pkg::WHEEL_W-1:0] wheel_fr;
   logic signed [mou_pkg::WHEEL_W-1:0] wheel_bl;
   logic signed [mou_pkg::WHEEL_W-1:0] wheel_br;
   logic [mou_pkg::HEAD_W-1:0]         heading;

   modport source (output valid, output wheel_fl, output wheel_fr, output wheel_bl,
                   output wheel_br, output heading, input ready);
   modport sink   (input valid, input wheel_fl, input wheel_fr, input wheel_bl,
                   input wheel_br, input heading, output ready);
endinterface

// ===== src/mou_rsp_if.sv =====
interface mou_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mou_pkg::VEL_W-1:0]  world_vx;
   logic signed [mou_pkg::VEL_W-1:0]  world_vy;
   logic signed [mou_pkg::RATE_W-1:0] yaw_rate;
   logic                              rate_saturated;

   modport source (output valid, output world_vx, output world_vy, output yaw_rate,
                   output rate_saturated, input ready);
   modport sink   (input valid, input world_vx, input world_vy, input yaw_rate,
                   input rate_saturated, output ready);
endinterface

// ===== src/mecanum_odometry_unit.sv =====
// channel  | dir | handshake          | payload
// req_bus  | in  | valid / ready      | wheel_fl, wheel_fr, wheel_bl, wheel_br, heading
// rsp_bus  | out | valid / ready      | world_vx, world_vy, yaw_rate, rate_saturated
// csr      | in  | csr_write_en       | csr_write_data -> geom_coef
//
// one request per cycle unless the output stalls; a response passes through the input
// stage, 24 chain cells, the product stage and the output register
// the chain length is set by the 24 quotient bits of the rate divider; the first
// 16 cells also perform one rotation step each
// a held output register stalls the whole chain; req_bus.ready follows it
// reset (synchronous) clears the valid bits and sets geom_coef to zero
module mecanum_odometry_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [mou_pkg::COEF_W-1:0] csr_write_data,
   mou_req_if.sink                    req_bus,
   mou_rsp_if.source                  rsp_bus
);

   // global advance, low only while a finished response is held
   logic advance;

   // chain taps: index 0 is the input stage, index NUM_CELLS the last cell
   logic                   chain_valid [mou_pkg::NUM_CELLS+1];
   mou_pkg::cell_data_type chain_data  [mou_pkg::NUM_CELLS+1];

   // sums, quadrant fold, divider setup and the coefficient register
   mou_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req            (req_bus),
      .valid_out      (chain_valid[0]),
      .data_out       (chain_data[0])
   );

   // each cell: one rotation step (early cells) and one quotient bit
   for (genvar g = 0; g < mou_pkg::NUM_CELLS; g++) begin : g_cell
      mou_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .step_idx   (mou_pkg::CELL_IDX_W'(g)),
         .valid_prev (chain_valid[g]),
         .data_prev  (chain_data[g]),
         .valid_out  (chain_valid[g+1]),
         .data_out   (chain_data[g+1])
      );
   end

   // gain correction, rounding, saturation and the output register
   mou_post u_post (
      .clock      (clock),
      .reset      (reset),
      .valid_prev (chain_valid[mou_pkg::NUM_CELLS]),
      .data_prev  (chain_data[mou_pkg::NUM_CELLS]),
      .advance    (advance),
      .rsp        (rsp_bus)
   );

endmodule

// ===== src/mou_prep.sv =====
module mou_prep (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        csr_write_en,
   input  logic [mou_pkg::COEF_W-1:0]  csr_write_data,
   mou_req_if.sink                     req,
   output logic                        valid_out,
   output mou_pkg::cell_data_type      data_out
);

   logic [mou_pkg::COEF_W-1:0] geom_coef_ff;
   logic                       valid_ff;
   mou_pkg::cell_data_type     data_ff;
   mou_pkg::cell_data_type     data_in;

   logic signed [mou_pkg::SUM_W-1:0] fl, fr, bl, br;
   logic signed [mou_pkg::SUM_W-1:0] sum_x, sum_y, sum_w;
   logic signed [mou_pkg::SUM_W+11:0] sx_scaled, sy_scaled;
   logic [mou_pkg::SUM_W-1:0] abs_w;
   logic                      flip;
   logic [31:0]               z_units;

   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_coef_ff <= '0;
      end else if (csr_write_en) begin
         geom_coef_ff <= csr_write_data;
      end
   end

   always_comb begin
      fl = mou_pkg::SUM_W'(req.wheel_fl);
      fr = mou_pkg::SUM_W'(req.wheel_fr);
      bl = mou_pkg::SUM_W'(req.wheel_bl);
      br = mou_pkg::SUM_W'(req.wheel_br);
      sum_x = fl + fr + bl + br;
      sum_y = fr + bl - fl - br;
      sum_w = fr + br - fl - bl;
      sx_scaled = {sum_x, 12'd0};
      sy_scaled = {sum_y, 12'd0};
      abs_w = sum_w[mou_pkg::SUM_W-1] ? mou_pkg::SUM_W'(-sum_w) : sum_w;

      // headings in the second and third quadrant: turn by half a turn first
      flip = req.heading[mou_pkg::HEAD_W-1] ^ req.heading[mou_pkg::HEAD_W-2];
      z_units = {req.heading ^ {flip, 15'd0}, 16'd0};

      data_in.x     = flip ? -mou_pkg::XY_W'(sx_scaled) : mou_pkg::XY_W'(sx_scaled);
      data_in.y     = flip ? -mou_pkg::XY_W'(sy_scaled) : mou_pkg::XY_W'(sy_scaled);
      data_in.z     = mou_pkg::Z_W'($signed(z_units));
      data_in.rem   = {abs_w, 11'd0} + mou_pkg::NUM_W'(geom_coef_ff);
      data_in.quot  = '0;
      data_in.den   = {geom_coef_ff, 1'b0};
      data_in.neg   = sum_w[mou_pkg::SUM_W-1];
      data_in.kzero = (geom_coef_ff == '0);
      data_in.ovf   = ({data_in.den, {mou_pkg::QUOT_BITS{1'b0}}}
                       <= mou_pkg::DSH_W'(data_in.rem));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ===== src/mou_cell.sv =====
module mou_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [mou_pkg::CELL_IDX_W-1:0]  step_idx,
   input  logic                            valid_prev,
   input  mou_pkg::cell_data_type          data_prev,
   output logic                            valid_out,
   output mou_pkg::cell_data_type          data_out
);

   logic                   valid_ff;
   mou_pkg::cell_data_type data_ff;
   mou_pkg::cell_data_type data_in;

   logic                            rotate_en;
   logic signed [mou_pkg::XY_W-1:0] dx, dy;
   logic signed [mou_pkg::Z_W-1:0]  angle;
   logic [mou_pkg::CELL_IDX_W-1:0]  bit_pos;
   logic [mou_pkg::DSH_W-1:0]       trial;

   always_comb begin
      data_in   = data_prev;
      rotate_en = (32'(step_idx) < mou_pkg::ANGLE_STEPS);
      dx        = data_prev.y >>> step_idx;
      dy        = data_prev.x >>> step_idx;
      angle     = mou_pkg::atan_units(step_idx);
      bit_pos   = mou_pkg::CELL_IDX_W'(mou_pkg::QUOT_BITS - 1) - step_idx;
      trial     = mou_pkg::DSH_W'(data_prev.den) << bit_pos;

      // one rotation step, driven toward zero residual angle
      if (rotate_en) begin
         if (!data_prev.z[mou_pkg::Z_W-1]) begin
            data_in.x = data_prev.x - dx;
            data_in.y = data_prev.y + dy;
            data_in.z = data_prev.z - angle;
         end else begin
            data_in.x = data_prev.x + dx;
            data_in.y = data_prev.y - dy;
            data_in.z = data_prev.z + angle;
         end
      end

      // one restoring divide step for the rate quotient
      if (mou_pkg::DSH_W'(data_prev.rem) >= trial) begin
         data_in.rem           = data_prev.rem - mou_pkg::NUM_W'(trial);
         data_in.quot[bit_pos] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ===== src/mou_post.sv =====
module mou_post (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_prev,
   input  mou_pkg::cell_data_type  data_prev,
   output logic                    advance,
   mou_rsp_if.source               rsp
);

   localparam logic [mou_pkg::QUOT_BITS-1:0] RATE_MAX = {1'b0, {(mou_pkg::QUOT_BITS-1){1'b1}}};
   localparam logic [mou_pkg::QUOT_BITS-1:0] RATE_MIN = {1'b1, {(mou_pkg::QUOT_BITS-1){1'b0}}};
   localparam logic [mou_pkg::PROD_W-1:0] ROUND_HALF =
      mou_pkg::PROD_W'(1) << (mou_pkg::ROUND_SHIFT - 1);

   // product stage
   logic                              mvalid_ff;
   logic signed [mou_pkg::PROD_W-1:0] px_ff, py_ff, px_in, py_in;
   logic [mou_pkg::QUOT_BITS-1:0]     quot_ff;
   logic                              neg_ff, kzero_ff, ovf_ff;

   // output register
   logic                              ovalid_ff;
   logic signed [mou_pkg::VEL_W-1:0]  vx_ff, vy_ff, vx_in, vy_in;
   logic signed [mou_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic                              clip_ff, clip_in;

   logic [mou_pkg::PROD_W-1:0]        tx, ty;
   logic signed [mou_pkg::VR_W-1:0]   rx, ry;

   function automatic logic signed [mou_pkg::VEL_W-1:0] sat_vel(
      input logic signed [mou_pkg::VR_W:0] val);
      logic signed [mou_pkg::VEL_W-1:0] res;
      if (val[mou_pkg::VR_W:mou_pkg::VEL_W-1] == '0 ||
          val[mou_pkg::VR_W:mou_pkg::VEL_W-1] == '1) begin
         res = val[mou_pkg::VEL_W-1:0];
      end else if (val[mou_pkg::VR_W]) begin
         res = {1'b1, {(mou_pkg::VEL_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(mou_pkg::VEL_W-1){1'b1}}};
      end
      return res;
   endfunction

   assign advance = !ovalid_ff || rsp.ready;

   assign px_in = data_prev.x * mou_pkg::KC;
   assign py_in = data_prev.y * mou_pkg::KC;

   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else if (advance) begin
         mvalid_ff <= valid_prev;
         ovalid_ff <= mvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         quot_ff  <= data_prev.quot;
         neg_ff   <= data_prev.neg;
         kzero_ff <= data_prev.kzero;
         ovf_ff   <= data_prev.ovf;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         rate_ff  <= rate_in;
         clip_ff  <= clip_in;
      end
   end

   always_comb begin
      // round to nearest, ties up, then drop gain and scale
      tx = px_ff + ROUND_HALF;
      ty = py_ff + ROUND_HALF;
      rx = $signed(tx[mou_pkg::PROD_W-1:mou_pkg::ROUND_SHIFT]);
      ry = $signed(ty[mou_pkg::PROD_W-1:mou_pkg::ROUND_SHIFT]);
      vx_in = sat_vel((mou_pkg::VR_W+1)'(rx));
      vy_in = sat_vel(-(mou_pkg::VR_W+1)'(ry));

      rate_in = '0;
      clip_in = 1'b0;
      if (kzero_ff) begin
         rate_in = '0;
         clip_in = 1'b0;
      end else if (ovf_ff) begin
         rate_in = neg_ff ? RATE_MIN : RATE_MAX;
         clip_in = 1'b1;
      end else if (!neg_ff) begin
         if (quot_ff > RATE_MAX) begin
            rate_in = RATE_MAX;
            clip_in = 1'b1;
         end else begin
            rate_in = quot_ff;
         end
      end else begin
         if (quot_ff > RATE_MIN) begin
            rate_in = RATE_MIN;
            clip_in = 1'b1;
         end else begin
            rate_in = ~quot_ff + mou_pkg::QUOT_BITS'(1);
         end
      end
   end

   assign rsp.valid          = ovalid_ff;
   assign rsp.world_vx       = vx_ff;
   assign rsp.world_vy       = vy_ff;
   assign rsp.yaw_rate       = rate_ff;
   assign rsp.rate_saturated = clip_ff;

endmodule
